// ----- design/assert_macros.svh -----
// assertion macros used by the sequencer (gbc_engine)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication, checked out of reset
`define GBC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/gbc_pkg.sv -----
// types and constants of the glyph blitter
`default_nettype none

package gbc_pkg;

  // input word actions
  typedef enum logic [2:0] {
    ACT_HEADER  = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_NEWLINE = 3'd2,
    ACT_READ    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FONT   = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_BIT,
    ST_MUL,
    ST_WR,
    ST_DONE
  } state_t;

  localparam logic [8:0] WIDTH_RESET  = 9'd128;
  localparam logic [8:0] HEIGHT_RESET = 9'd128;
  localparam logic [6:0] FONT_RESET   = 7'd20;

  typedef struct packed {
    logic [8:0] canvas_width;
    logic [8:0] canvas_height;
    logic [6:0] font_size;
  } cfg_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  pixels_set;
    logic [3:0]  pixels_clipped;
  } res_t;

endpackage

`default_nettype wire

// ----- design/gbc_if.sv -----
// valid/ready channel interfaces for input and result words
`default_nettype none

interface gbc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       glyph_found;
  logic [7:0] box_left;
  logic [7:0] box_top;
  logic [7:0] box_right;
  logic [7:0] box_bottom;
  logic [7:0] glyph_byte;
  logic [9:0] word_address;

  modport source (
    output valid, action, glyph_found, box_left, box_top, box_right, box_bottom,
    output glyph_byte, word_address,
    input  ready
  );
  modport sink (
    input  valid, action, glyph_found, box_left, box_top, box_right, box_bottom,
    input  glyph_byte, word_address,
    output ready
  );
endinterface

interface gbc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [3:0]  pixels_set;
  logic [3:0]  pixels_clipped;

  modport source (
    output valid, read_data, pixels_set, pixels_clipped,
    input  ready
  );
  modport sink (
    input  valid, read_data, pixels_set, pixels_clipped,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/glyph_blit_1bpp_canvas.sv -----
// Glyph blitter top level: config registers, sequencer, canvas store, result register
//
// Usage: items arrive on the glyph channel (valid/ready). A header sets the
// glyph box and advances the cursor, data bytes draw up to eight pixels
// each, newline moves the cursor, read returns a canvas word, clear wipes
// the canvas. Every item gives exactly one word on the result channel.
// From accept to the result register, a read waits for the registered
// word read; a data byte takes bit steps (the bits taken, plus one more
// when the glyph runs out before the eighth), a word read and a write-back
// for each pixel landing in the canvas, and an address step for each pixel
// dropped for lying past the word store. Clear zeroes every canvas word.
// One item is worked on at a time.
// Reset: a clearing pass over all CANVAS_WORDS words runs first, glyph.ready
// stays low until it ends; configuration writes are taken at any time.
// A stalled receiver holds the result word; the next item is accepted and
// worked on meanwhile, and only its delivery waits for the result slot.
`default_nettype none

module glyph_blit_1bpp_canvas
  import gbc_pkg::*;
#(
  parameter int CANVAS_WORDS = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  gbc_in_if.sink          glyph,
  gbc_out_if.source       result,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  localparam int AW = $clog2(CANVAS_WORDS);

  cfg_t          cfg;
  res_t          res, out_word;
  logic          res_valid, res_take, out_valid;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width  <= WIDTH_RESET;
      cfg.canvas_height <= HEIGHT_RESET;
      cfg.font_size     <= FONT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg.canvas_width  <= cfg_data;
        CFG_HEIGHT: cfg.canvas_height <= cfg_data;
        CFG_FONT:   cfg.font_size     <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  gbc_engine #(
    .CANVAS_WORDS (CANVAS_WORDS),
    .AW           (AW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .glyph     (glyph),
    .cfg       (cfg),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  gbc_ram #(
    .DEPTH (CANVAS_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register between the sequencer and the receiver
  assign res_take = res_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.read_data      = out_word.read_data;
  assign result.pixels_set     = out_word.pixels_set;
  assign result.pixels_clipped = out_word.pixels_clipped;

endmodule

`default_nettype wire

// ----- design/gbc_ram.sv -----
// canvas word store, one write and one registered read port
`default_nettype none

module gbc_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/gbc_engine.sv -----
// sequencer: cursor and glyph state, per-pixel read-modify-write of the canvas
`default_nettype none
`include "assert_macros.svh"

module gbc_engine
  import gbc_pkg::*;
#(
  parameter int CANVAS_WORDS = 1024,
  parameter int AW           = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  gbc_in_if.sink             glyph,
  input  wire cfg_t          cfg,
  output res_t               res,
  output logic               res_valid,
  input  wire logic          res_take,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [15:0]        ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [15:0]   ram_rdata
);

  localparam logic [AW-1:0] LAST_WORD = AW'(CANVAS_WORDS - 1);
  localparam logic [2:0]    TOP_BIT   = 3'd7;
  localparam logic [4:0]    MAX_PIX   = 5'd8;

  state_t state, state_next;

  logic [15:0] cursor_x, cursor_y;
  logic [7:0]  offset_x, offset_y, cur_width, cur_height;
  logic [15:0] bit_index, total_bits;
  logic [7:0]  gx, gy;
  logic [7:0]  byte_reg;
  logic [2:0]  k;
  logic        bit_last;
  logic [7:0]  px, py;
  logic [AW-1:0] wr_addr, clr_addr;
  logic [3:0]  wr_bit;
  logic        clr_reply;
  logic [15:0] res_data;
  logic [3:0]  set_cnt, clip_cnt;

  logic        accept;
  logic [7:0]  hdr_w, hdr_h;
  logic [15:0] hdr_total;
  logic [31:0] rd_ext, word_ext;
  logic        rd_ok, word_ok;
  logic        glyph_done, cur_bit, on_canvas, last_clr;
  logic [15:0] origin_x, cx, cy, pos;

  // input word decode
  assign accept    = glyph.valid && glyph.ready;
  assign hdr_w     = glyph.box_right - glyph.box_left;
  assign hdr_h     = glyph.box_bottom - glyph.box_top;
  assign hdr_total = 16'(hdr_w) * 16'(hdr_h);
  assign rd_ext    = 32'(glyph.word_address);
  assign rd_ok     = rd_ext < 32'(CANVAS_WORDS);

  // pixel geometry of the current glyph bit
  assign glyph_done = bit_index >= total_bits;
  assign cur_bit    = byte_reg[k];
  assign origin_x   = cursor_x - 16'(cur_width);
  assign cx         = origin_x + 16'(offset_x) + 16'(gx);
  assign cy         = cursor_y + 16'(offset_y) + 16'(gy);
  assign on_canvas  = (cx < 16'(cfg.canvas_width)) && (cy < 16'(cfg.canvas_height));

  // bit position of the pixel in the canvas, from the registered coordinates
  assign pos      = 16'(py) * 16'(cfg.canvas_width) + 16'(px);
  assign word_ext = 32'(pos[15:4]);
  assign word_ok  = word_ext < 32'(CANVAS_WORDS);
  assign last_clr = clr_addr == LAST_WORD;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (last_clr) state_next = clr_reply ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (glyph.action)
            ACT_DATA:  state_next = ST_BIT;
            ACT_READ:  state_next = rd_ok ? ST_RDWAIT : ST_DONE;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_BIT: begin
        if (glyph_done) begin
          state_next = ST_DONE;
        end else if (cur_bit && on_canvas) begin
          state_next = ST_MUL;
        end else begin
          state_next = (k == 3'd0) ? ST_DONE : ST_BIT;
        end
      end
      ST_MUL: begin
        if (word_ok) state_next = ST_WR;
        else         state_next = bit_last ? ST_DONE : ST_BIT;
      end
      ST_WR:   state_next = bit_last ? ST_DONE : ST_BIT;
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and memory controls
  assign glyph.ready = state == ST_IDLE;

  always_comb begin
    res_valid = state == ST_DONE;
    ram_re    = (accept && (glyph.action == ACT_READ) && rd_ok)
                || ((state == ST_MUL) && word_ok);
    ram_raddr = (state == ST_MUL) ? word_ext[AW-1:0] : rd_ext[AW-1:0];
    ram_we    = (state == ST_CLEAR) || (state == ST_WR);
    ram_waddr = (state == ST_CLEAR) ? clr_addr : wr_addr;
    ram_wdata = (state == ST_CLEAR) ? 16'h0000
                                    : (ram_rdata | (16'h8000 >> wr_bit));
  end

  assign res.read_data      = res_data;
  assign res.pixels_set     = set_cnt;
  assign res.pixels_clipped = clip_cnt;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      cursor_x   <= '0;
      cursor_y   <= '0;
      offset_x   <= '0;
      offset_y   <= '0;
      cur_width  <= '0;
      cur_height <= '0;
      bit_index  <= '0;
      total_bits <= '0;
      gx         <= '0;
      gy         <= '0;
      set_cnt    <= '0;
      clip_cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          clr_addr <= last_clr ? '0 : clr_addr + AW'(1);
          if (last_clr) clr_reply <= 1'b0;
        end
        ST_IDLE: begin
          if (accept) begin
            res_data <= '0;
            set_cnt  <= '0;
            clip_cnt <= '0;
            byte_reg <= glyph.glyph_byte;
            k        <= TOP_BIT;
            case (glyph.action)
              ACT_HEADER: begin
                bit_index <= '0;
                gx        <= '0;
                gy        <= '0;
                if (glyph.glyph_found) begin
                  offset_x   <= glyph.box_left;
                  offset_y   <= glyph.box_top;
                  cur_width  <= hdr_w;
                  cur_height <= hdr_h;
                  total_bits <= hdr_total;
                  cursor_x   <= cursor_x + 16'(hdr_w);
                end else begin
                  cur_width  <= '0;
                  cur_height <= '0;
                  total_bits <= '0;
                  cursor_x   <= cursor_x + 16'(cfg.font_size);
                end
              end
              ACT_NEWLINE: begin
                cursor_x   <= '0;
                cursor_y   <= cursor_y + 16'(cfg.font_size);
                cur_width  <= '0;
                cur_height <= '0;
                total_bits <= '0;
                bit_index  <= '0;
                gx         <= '0;
                gy         <= '0;
              end
              ACT_CLEAR: begin
                clr_reply <= 1'b1;
                clr_addr  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RDWAIT: res_data <= ram_rdata;
        ST_BIT: begin
          if (!glyph_done) begin
            bit_index <= bit_index + 16'd1;
            // row-major walk through the glyph box
            if (gx == cur_width - 8'd1) begin
              gx <= '0;
              gy <= gy + 8'd1;
            end else begin
              gx <= gx + 8'd1;
            end
            k        <= k - 3'd1;
            bit_last <= k == 3'd0;
            px       <= cx[7:0];
            py       <= cy[7:0];
            if (cur_bit && !on_canvas) clip_cnt <= clip_cnt + 4'd1;
          end
        end
        ST_MUL: begin
          wr_addr <= word_ext[AW-1:0];
          wr_bit  <= pos[3:0];
          if (!word_ok) clip_cnt <= clip_cnt + 4'd1;
        end
        ST_WR: set_cnt <= set_cnt + 4'd1;
        default: begin
        end
      endcase
    end
  end

  // checks
  `GBC_ASSERT(a_count_bound, clk, rst, (5'(set_cnt) + 5'(clip_cnt)) <= MAX_PIX, "too many pixels counted for one byte")
  `GBC_ASSERT(a_bit_index_bound, clk, rst, bit_index <= total_bits, "bit index ran past the glyph box")
  `GBC_ASSERT_IMP(a_wr_after_rd, clk, rst, state == ST_WR, $past(ram_re), "pixel write without a preceding word read")
  `GBC_ASSERT_IMP(a_clear_zero, clk, rst, state == ST_CLEAR, ram_we && (ram_wdata == 16'h0000), "clearing pass not writing zero")

endmodule

`default_nettype wire

// ----- tb/tb_glyph_blit_1bpp_canvas.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the 1bpp glyph blitter: directed cases, then random glyph traffic
module tb_glyph_blit_1bpp_canvas
  import gbc_pkg::*;
();

  localparam int CANVAS_WORDS = 1024;
  localparam int MAX_REPORTS  = 40;

  // one word on the glyph channel
  typedef struct packed {
    logic [2:0] action;
    logic       glyph_found;
    logic [7:0] box_left;
    logic [7:0] box_top;
    logic [7:0] box_right;
    logic [7:0] box_bottom;
    logic [7:0] glyph_byte;
    logic [9:0] word_address;
  } glyph_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  logic       take_ready = 1'b0;

  gbc_in_if  glyph_ch ();
  gbc_out_if result_ch ();

  assign result_ch.ready = take_ready;

  glyph_blit_1bpp_canvas #(
    .CANVAS_WORDS(CANVAS_WORDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .glyph    (glyph_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted canvas, cursor and glyph state
  logic [15:0] canvas_m [CANVAS_WORDS];
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] bits_used;
  logic [7:0]  box_dx;
  logic [7:0]  box_dy;
  logic [7:0]  glyph_w;
  logic [7:0]  glyph_h;
  logic [8:0]  canvas_w;
  logic [8:0]  canvas_h;
  logic [6:0]  font_px;
  int          last_word;

  res_t due_answers[$];
  bit   eager;
  int   words_sent;
  int   results_seen;
  int   fail_count;
  int   reports;
  int   sink_hold;
  int   pixels_drawn;
  int   pixels_dropped;

  // works out the answer word for one accepted item and updates the canvas copy
  task automatic blit_model(input glyph_word_t w, output res_t ans);
    int total, ox, gx, gy, cx, cy, pos, wd;
    ans = '0;
    case (w.action)
      ACT_HEADER: begin
        if (w.glyph_found) begin
          box_dx    = w.box_left;
          box_dy    = w.box_top;
          glyph_w   = w.box_right - w.box_left;
          glyph_h   = w.box_bottom - w.box_top;
          bits_used = '0;
          pen_x     = pen_x + 16'(glyph_w);
        end else begin
          glyph_w   = '0;
          glyph_h   = '0;
          bits_used = '0;
          pen_x     = pen_x + 16'(font_px);
        end
      end
      ACT_DATA: begin
        total = int'(glyph_w) * int'(glyph_h);
        // glyph origin is the cursor before the header advanced it
        ox = (int'(pen_x) - int'(glyph_w)) & 'hFFFF;
        for (int k = 7; k >= 0; k--) begin
          if (int'(bits_used) < total) begin
            gy = int'(bits_used) / int'(glyph_w);
            gx = int'(bits_used) % int'(glyph_w);
            bits_used = bits_used + 16'd1;
            if (w.glyph_byte[k]) begin
              cx = (ox + int'(box_dx) + gx) & 'hFFFF;
              cy = (int'(pen_y) + int'(box_dy) + gy) & 'hFFFF;
              if (cx >= int'(canvas_w) || cy >= int'(canvas_h)) begin
                ans.pixels_clipped = ans.pixels_clipped + 4'd1;
              end else begin
                pos = cy * int'(canvas_w) + cx;
                wd  = pos >> 4;
                if (wd >= CANVAS_WORDS) begin
                  ans.pixels_clipped = ans.pixels_clipped + 4'd1;
                end else begin
                  canvas_m[wd][15 - (pos % 16)] = 1'b1;
                  ans.pixels_set = ans.pixels_set + 4'd1;
                  last_word = wd;
                end
              end
            end
          end
        end
      end
      ACT_NEWLINE: begin
        pen_x     = '0;
        pen_y     = pen_y + 16'(font_px);
        glyph_w   = '0;
        glyph_h   = '0;
        bits_used = '0;
      end
      ACT_READ: begin
        if (int'(w.word_address) < CANVAS_WORDS) ans.read_data = canvas_m[w.word_address];
      end
      ACT_CLEAR: begin
        foreach (canvas_m[i]) canvas_m[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  // result side: random stall after each word, check against the oldest answer due
  always @(posedge clk) begin : result_check
    res_t due;
    int   hold;
    if (rst) begin
      take_ready <= 1'b0;
      sink_hold  <= 0;
    end else if (result_ch.valid && take_ready) begin
      results_seen++;
      if (due_answers.size() == 0) begin
        fail_count++;
        if (reports < MAX_REPORTS) $error("result word arrived with no answer due");
        reports++;
      end else begin
        due = due_answers.pop_front();
        if (result_ch.read_data !== due.read_data) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $error("read_data expected %h got %h", due.read_data, result_ch.read_data);
          reports++;
        end
        if (result_ch.pixels_set !== due.pixels_set) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $error("pixels_set expected %0d got %0d", due.pixels_set, result_ch.pixels_set);
          reports++;
        end
        if (result_ch.pixels_clipped !== due.pixels_clipped) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $error("pixels_clipped expected %0d got %0d", due.pixels_clipped,
                   result_ch.pixels_clipped);
          reports++;
        end
      end
      hold = eager ? 0 : $urandom_range(0, 7);
      sink_hold  <= hold;
      take_ready <= (hold == 0);
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_hold  <= 0;
      take_ready <= 1'b1;
    end
  end

  // every field random, so unused fields of each action get exercised
  function automatic glyph_word_t noise_word();
    glyph_word_t w;
    w.action       = 3'($urandom_range(0, 7));
    w.glyph_found  = 1'($urandom_range(0, 1));
    w.box_left     = 8'($urandom_range(0, 255));
    w.box_top      = 8'($urandom_range(0, 255));
    w.box_right    = 8'($urandom_range(0, 255));
    w.box_bottom   = 8'($urandom_range(0, 255));
    w.glyph_byte   = 8'($urandom_range(0, 255));
    w.word_address = 10'($urandom_range(0, 1023));
    return w;
  endfunction

  // drive one word, wait for it to be taken, then log its answer
  task automatic send_word(input glyph_word_t w);
    int   gap;
    res_t ans;
    gap = eager ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      glyph_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    glyph_ch.valid        <= 1'b1;
    glyph_ch.action       <= w.action;
    glyph_ch.glyph_found  <= w.glyph_found;
    glyph_ch.box_left     <= w.box_left;
    glyph_ch.box_top      <= w.box_top;
    glyph_ch.box_right    <= w.box_right;
    glyph_ch.box_bottom   <= w.box_bottom;
    glyph_ch.glyph_byte   <= w.glyph_byte;
    glyph_ch.word_address <= w.word_address;
    do @(posedge clk); while (glyph_ch.ready !== 1'b1);
    blit_model(w, ans);
    due_answers.push_back(ans);
    words_sent++;
    pixels_drawn   += ans.pixels_set;
    pixels_dropped += ans.pixels_clipped;
  endtask

  task automatic send_act(input logic [2:0] a);
    glyph_word_t w;
    w = noise_word();
    w.action = a;
    send_word(w);
  endtask

  task automatic send_header(input logic found, input logic [7:0] l, input logic [7:0] t,
                             input logic [7:0] r, input logic [7:0] b);
    glyph_word_t w;
    w = noise_word();
    w.action      = ACT_HEADER;
    w.glyph_found = found;
    w.box_left    = l;
    w.box_top     = t;
    w.box_right   = r;
    w.box_bottom  = b;
    send_word(w);
  endtask

  task automatic send_data(input logic [7:0] bits);
    glyph_word_t w;
    w = noise_word();
    w.action     = ACT_DATA;
    w.glyph_byte = bits;
    send_word(w);
  endtask

  task automatic send_read(input logic [9:0] addr);
    glyph_word_t w;
    w = noise_word();
    w.action       = ACT_READ;
    w.word_address = addr;
    send_word(w);
  endtask

  // stop sending and wait for every answer to come back
  task automatic settle();
    glyph_ch.valid <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reprogram all three registers while the block is idle
  task automatic set_canvas(input logic [8:0] w, input logic [8:0] h, input logic [6:0] f);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_FONT;
    cfg_data  <= {2'b00, f};
    @(posedge clk);
    cfg_we    <= 1'b0;
    canvas_w = w;
    canvas_h = h;
    font_px  = f;
  endtask

  // canvas reads zero after the clearing pass; unknown actions answer zero
  task automatic test_reset_state();
    send_read(10'd0);
    send_read(10'(CANVAS_WORDS - 1));
    for (int a = ACT_CLEAR + 1; a < 8; a++) send_act(3'(a));
  endtask

  // small box, partial last byte, and a byte past the end of the glyph
  task automatic test_simple_glyph();
    send_header(1'b1, 8'd1, 8'd2, 8'd5, 8'd5);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'hFF);
    send_read(10'd16);
    send_read(10'd32);
  endtask

  // missing glyph, newline, wrapped box width and a zero-height box
  task automatic test_missing_and_newline();
    send_header(1'b0, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_data(8'hFF);
    send_act(ACT_NEWLINE);
    send_header(1'b1, 8'd250, 8'd0, 8'd2, 8'd1);
    send_data(8'hFF);
    send_header(1'b1, 8'd0, 8'd0, 8'd7, 8'd0);
    send_data(8'hFF);
    send_read(10'd160);
  endtask

  // widest canvas: pixels beyond the word store, and a row straddling the right edge
  task automatic test_canvas_edges();
    set_canvas(9'd256, 9'd256, 7'd1);
    send_header(1'b1, 8'd0, 8'd200, 8'd16, 8'd201);
    send_data(8'hFF);
    send_data(8'hFF);
    send_header(1'b1, 8'd221, 8'd0, 8'd229, 8'd1);
    send_data(8'hFF);
  endtask

  // clear wipes the canvas only
  task automatic test_clear();
    send_read(10'(last_word));
    send_act(ACT_CLEAR);
    send_read(10'(last_word));
  endtask

  // mostly well-formed glyphs with random content, plus noise and broken sequences
  task automatic run_random(input int count);
    int goal, pick, gw, gh, gl, gt, nbytes;
    goal = words_sent + count;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        gw = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
        gh = (gw > 12) ? $urandom_range(0, 2) : $urandom_range(0, 12);
        gl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        gt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        send_header(1'b1, 8'(gl), 8'(gt), 8'(gl + gw), 8'(gt + gh));
        nbytes = (gw * gh + 7) / 8;
        // sometimes one byte too many or too few
        case ($urandom_range(0, 5))
          0: nbytes++;
          1: if (nbytes > 0) nbytes--;
          default: ;
        endcase
        if (nbytes > 40) nbytes = 40;
        repeat (nbytes) send_data(8'($urandom_range(0, 255)));
      end else if (pick < 63) begin
        send_header(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 68) begin
        send_act(ACT_NEWLINE);
      end else if (pick < 84) begin
        if ($urandom_range(0, 1) == 1)
          send_read(10'((last_word + $urandom_range(0, 2)) % CANVAS_WORDS));
        else
          send_read(10'($urandom_range(0, CANVAS_WORDS - 1)));
      end else if (pick < 85) begin
        send_act(ACT_CLEAR);
      end else if (pick < 88) begin
        // hold off until the block has drained, then maybe run without gaps
        settle();
        eager = ($urandom_range(0, 3) == 0);
      end else begin
        send_word(noise_word());
      end
    end
  endtask

  // random traffic over several canvas settings, extremes included
  task automatic test_random_traffic();
    eager = 1'b0;
    set_canvas(9'd256, 9'd256, 7'd1);
    run_random(130);
    set_canvas(9'd200, 9'd256, 7'd3);
    run_random(120);
    eager = 1'b1;
    set_canvas(9'd256, 9'd200, 7'd2);
    run_random(110);
    eager = 1'b0;
    set_canvas(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
               7'($urandom_range(1, 64)));
    run_random(120);
    set_canvas(9'd1, 9'd1, 7'd64);
    run_random(90);
  endtask

  initial begin
    glyph_ch.valid        <= 1'b0;
    glyph_ch.action       <= ACT_HEADER;
    glyph_ch.glyph_found  <= 1'b0;
    glyph_ch.box_left     <= '0;
    glyph_ch.box_top      <= '0;
    glyph_ch.box_right    <= '0;
    glyph_ch.box_bottom   <= '0;
    glyph_ch.glyph_byte   <= '0;
    glyph_ch.word_address <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= '0;
    // predicted state after reset
    foreach (canvas_m[i]) canvas_m[i] = '0;
    pen_x     = '0;
    pen_y     = '0;
    bits_used = '0;
    box_dx    = '0;
    box_dy    = '0;
    glyph_w   = '0;
    glyph_h   = '0;
    canvas_w  = WIDTH_RESET;
    canvas_h  = HEIGHT_RESET;
    font_px   = FONT_RESET;
    last_word = 0;
    eager     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_simple_glyph();
    test_missing_and_newline();
    test_canvas_edges();
    test_clear();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    $display("%0d words sent, %0d result words checked", words_sent, results_seen);
    $display("%0d pixels drawn and %0d clipped across six canvas settings",
             pixels_drawn, pixels_dropped);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
